// ===== hdl/lsef_pkg.sv =====
// Package for the line scan edge finder: field widths, the running
// extreme types and their start values, and the per-line result word.
// No dependencies.
`timescale 1ns / 1ps

package lsef_pkg;

   localparam int PIXEL_W = 12;
   localparam int EDGE_W  = 7;

   // pixel difference spans -4095..4095
   typedef logic signed [PIXEL_W:0]   rise_type;
   // running minimum starts above every difference
   typedef logic signed [PIXEL_W+1:0] fall_type;

   localparam rise_type RISE_START = -rise_type'(1);
   localparam fall_type FALL_START = fall_type'(8191);

   typedef struct packed {
      logic [EDGE_W-1:0] left_edge;
      logic [EDGE_W-1:0] right_edge;
      logic [EDGE_W-1:0] centre;
      logic              fell_back;
   } lsef_result_type;

endpackage

// ===== hdl/lsef_edge_track.sv =====
// Per-line edge tracking: pixel difference, strongest rise and fall,
// and the end-of-line result. Depends on lsef_pkg.
`timescale 1ns / 1ps

module lsef_edge_track
   import lsef_pkg::*;
#(
   parameter int LINE_WIDTH  = 128,
   parameter int START_INDEX = 10,
   parameter int END_MARGIN  = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,      // one pixel word consumed
   input  logic [PIXEL_W-1:0]   pixel,
   input  logic                 line_end,
   output lsef_result_type      result     // valid with step on the last pixel
);

   localparam int POS_W  = $clog2(LINE_WIDTH + 1);
   localparam int WIDE_W = (POS_W > EDGE_W) ? POS_W : EDGE_W;
   localparam logic [POS_W-1:0] WIN_START = POS_W'(START_INDEX);
   localparam logic [POS_W-1:0] WIN_END   = POS_W'(LINE_WIDTH - END_MARGIN);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_WIDTH);

   logic [PIXEL_W-1:0] prev_ff, prev_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   rise_type           rise_ff, rise_in;
   fall_type           fall_ff, fall_in;
   logic [POS_W-1:0]   left_ff, left_in;
   logic [POS_W-1:0]   right_ff, right_in;

   rise_type           diff;
   logic               in_window;
   logic               new_rise;
   logic               new_fall;
   rise_type           rise_upd;
   fall_type           fall_upd;
   logic [POS_W-1:0]   left_upd;
   logic [POS_W-1:0]   right_upd;
   logic               crossed;
   logic [WIDE_W-1:0]  left_wide;
   logic [WIDE_W-1:0]  right_wide;
   logic [WIDE_W:0]    sum;

   // difference and compares for the current pixel
   always_comb begin
      diff      = rise_type'({1'b0, pixel}) - rise_type'({1'b0, prev_ff});
      in_window = (pos_ff >= WIN_START) && (pos_ff < WIN_END);
      new_rise  = in_window && (diff > rise_ff);
      new_fall  = in_window && (fall_type'(diff) < fall_ff);
      rise_upd  = new_rise ? diff : rise_ff;
      fall_upd  = new_fall ? fall_type'(diff) : fall_ff;
      left_upd  = new_rise ? pos_ff : left_ff;
      right_upd = new_fall ? pos_ff : right_ff;
   end

   // end-of-line result; crossed edges fall back to the window ends
   always_comb begin
      crossed    = left_upd > right_upd;
      left_wide  = crossed ? WIDE_W'(WIN_START) : WIDE_W'(left_upd);
      right_wide = crossed ? WIDE_W'(WIN_END)   : WIDE_W'(right_upd);
      sum        = (WIDE_W + 1)'(left_wide) + (WIDE_W + 1)'(right_wide);
      result.left_edge  = left_wide[EDGE_W-1:0];
      result.right_edge = right_wide[EDGE_W-1:0];
      result.centre     = sum[EDGE_W:1];
      result.fell_back  = crossed;
   end

   // next state: new line after the last pixel, else keep tracking
   always_comb begin
      prev_in  = prev_ff;
      pos_in   = pos_ff;
      rise_in  = rise_ff;
      fall_in  = fall_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (step) begin
         prev_in = pixel;
         if (line_end) begin
            pos_in   = '0;
            rise_in  = RISE_START;
            fall_in  = FALL_START;
            left_in  = WIN_START;
            right_in = WIN_END;
         end else begin
            pos_in   = (pos_ff < POS_LIMIT) ? pos_ff + POS_W'(1) : pos_ff;
            rise_in  = rise_upd;
            fall_in  = fall_upd;
            left_in  = left_upd;
            right_in = right_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         pos_ff   <= '0;
         rise_ff  <= RISE_START;
         fall_ff  <= FALL_START;
         left_ff  <= WIN_START;
         right_ff <= WIN_END;
      end else begin
         prev_ff  <= prev_in;
         pos_ff   <= pos_in;
         rise_ff  <= rise_in;
         fall_ff  <= fall_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

endmodule

// ===== hdl/line_scan_edge_finder.sv =====
// Line scan edge finder. Throughput: one pixel word per cycle.
// The result word for a line is written into the result register when the last
// pixel of the line moves on from the input register (the tracking logic runs
// between the two). The input stalls only while a line end waits on an
// unaccepted result word. Reset (synchronous, active high) empties both
// registers and starts a fresh line with the previous pixel at zero.
`timescale 1ns / 1ps

module line_scan_edge_finder
   import lsef_pkg::*;
#(
   parameter int LINE_WIDTH  = 128,
   parameter int START_INDEX = 10,
   parameter int END_MARGIN  = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] pixel, [15:12] zero
   input  logic        req_tlast,   // line_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [6:0] left_edge, [13:7] right_edge,
                                    // [20:14] centre, [23:21] zero
   output logic [0:0]  rsp_tuser    // [0] fell_back
);

   logic               in_valid_ff, in_valid_in;
   logic [PIXEL_W-1:0] in_pixel_ff;
   logic               in_last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   lsef_result_type    rsp_data_ff;
   lsef_result_type    line_result;
   logic               advance;
   logic               accept;

   // a held pixel moves on unless it ends a line, the result slot is full and rsp_tready is low
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   lsef_edge_track #(
      .LINE_WIDTH  (LINE_WIDTH),
      .START_INDEX (START_INDEX),
      .END_MARGIN  (END_MARGIN)
   ) u_track (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .pixel    (in_pixel_ff),
      .line_end (in_last_ff),
      .result   (line_result)
   );

   // valid flags of both registers
   always_comb begin
      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_pixel_ff <= req_tdata[PIXEL_W-1:0];
         in_last_ff  <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= line_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff.centre, rsp_data_ff.right_edge,
                        rsp_data_ff.left_edge};
   assign rsp_tuser  = rsp_data_ff.fell_back;

endmodule

// ===== bench/line_scan_edge_finder_tb.sv =====
// Self-checking bench for line_scan_edge_finder: short directed lines, then random lines
// of many shapes, checked word by word against an in-bench edge tracker or a table value.
// Depends on lsef_pkg and line_scan_edge_finder.
`timescale 1ns / 1ps

module line_scan_edge_finder_tb;
   import lsef_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int LINE_LEN     = 128;
   localparam int WIN_FIRST    = 10;
   localparam int WIN_TAIL     = 11;
   localparam int WIN_END      = LINE_LEN - WIN_TAIL;   // first position past the window
   localparam int LIMIT_CYCLES = 300000;
   localparam int CHOKE_CYCLES = 400;
   localparam int RANDOM_WORDS = 650;
   localparam int RANDOM_LINES = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   line_scan_edge_finder #(
      .LINE_WIDTH  (LINE_LEN),
      .START_INDEX (WIN_FIRST),
      .END_MARGIN  (WIN_TAIL)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // edge tracker state, one line at a time
   logic [PIXEL_W-1:0] prev_px  = '0;
   int                 px_pos   = 0;
   rise_type           top_rise = RISE_START;
   fall_type           low_fall = FALL_START;
   int                 rise_at  = WIN_FIRST;
   int                 fall_at  = WIN_END;

   lsef_result_type line_results[$];

   int mismatches = 0;
   int words_sent = 0;
   int lines_sent = 0;
   int burst_left = 0;

   // receiver hold-off requests, served by the receiver process
   int choke_asks = 0;
   int choke_seen = 0;
   int choke_left = 0;
   int ready_run  = 0;

   // directed lines; typed rows carry an expectation readable at a glance
   typedef struct {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
      int                 count;
      bit                 typed;
      lsef_result_type    want;
   } drill_row_type;

   drill_row_type drill_rows [6] = '{
      // one-pixel line, nothing in the window: window ends
      '{12'd0,    1'b1, 1,  1'b1, '{7'd10, 7'd117, 7'd63, 1'b0}},
      // full-scale rise at the first window position, rise and fall both land there
      '{12'd0,    1'b0, 10, 1'b0, '0},
      '{12'd4095, 1'b1, 1,  1'b1, '{7'd10, 7'd10, 7'd10, 1'b0}},
      // full-scale fall then rise: left lies beyond right, fall back
      '{12'd4095, 1'b0, 10, 1'b0, '0},
      '{12'd0,    1'b0, 1,  1'b0, '0},
      '{12'd4095, 1'b1, 1,  1'b1, '{7'd10, 7'd117, 7'd63, 1'b1}}
   };

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // advance the tracker by one pixel; queues a result on the line end
   function automatic void track_pixel(input logic [PIXEL_W-1:0] px, input logic last);
      int              step;
      int              l;
      int              r;
      lsef_result_type res;
      if (px_pos >= WIN_FIRST && px_pos < WIN_END) begin
         step = int'(px) - int'(prev_px);
         if (step > int'(top_rise)) begin
            top_rise = rise_type'(step);
            rise_at  = px_pos;
         end
         if (step < int'(low_fall)) begin
            low_fall = fall_type'(step);
            fall_at  = px_pos;
         end
      end
      prev_px = px;
      if (px_pos < LINE_LEN)
         px_pos++;
      if (last) begin
         l = rise_at;
         r = fall_at;
         res.fell_back = 1'b0;
         if (l > r) begin
            l = WIN_FIRST;
            r = WIN_END;
            res.fell_back = 1'b1;
         end
         res.left_edge  = EDGE_W'(l);
         res.right_edge = EDGE_W'(r);
         res.centre     = EDGE_W'((l + r) / 2);
         line_results.push_back(res);
         // fresh line, previous pixel carries over
         px_pos   = 0;
         top_rise = RISE_START;
         low_fall = FALL_START;
         rise_at  = WIN_FIRST;
         fall_at  = WIN_END;
      end
   endfunction

   // offer one pixel word in bursts with random gaps; returns once accepted
   task automatic push_pixel(input logic [PIXEL_W-1:0] px, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, px};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      track_pixel(px, last);
      words_sent++;
   endtask

   // one random line: bright or dark stripe with noise, pure noise, or tie-heavy levels
   task automatic send_line(input int len);
      int kind;
      int bg;
      int fg;
      int swap;
      int rise_pos;
      int fall_pos;
      int noise;
      int v;
      kind     = $urandom_range(0, 9);
      bg       = $urandom_range(0, 1200);
      fg       = $urandom_range(1500, 4095);
      rise_pos = $urandom_range(0, len);
      fall_pos = $urandom_range(rise_pos, len);
      noise    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
      if (kind >= 8) begin
         swap = bg;
         bg   = fg;
         fg   = swap;
      end
      for (int i = 0; i < len; i++) begin
         if (kind <= 4 || kind >= 8) begin
            v = (i >= rise_pos && i < fall_pos) ? fg : bg;
            v = v + $urandom_range(0, noise);
            if (v > 4095)
               v = 4095;
         end else if (kind <= 6) begin
            v = $urandom_range(0, 4095);
         end else begin
            case ($urandom_range(0, 2))
               0: v = 0;
               1: v = 2048;
               default: v = 4095;
            endcase
         end
         push_pixel(PIXEL_W'(v), i == len - 1);
      end
      lines_sent++;
   endtask

   // mostly short lines so results come often; some full and overlong ones
   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10)
         return $urandom_range(1, 24);
      else if (r < 15)
         return $urandom_range(25, WIN_END);
      else if (r < 18)
         return $urandom_range(WIN_END + 1, LINE_LEN);
      else
         return $urandom_range(LINE_LEN + 1, LINE_LEN + 32);
   endfunction

   // stop offering and wait until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (line_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // receiver: runs of ready, random stalls, and long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_run  <= 0;
         choke_left <= 0;
      end else if (choke_seen != choke_asks) begin
         choke_seen <= choke_asks;
         choke_left <= CHOKE_CYCLES;
         rsp_tready <= 1'b0;
      end else if (choke_left != 0) begin
         choke_left <= choke_left - 1;
         rsp_tready <= 1'b0;
      end else if (ready_run != 0) begin
         ready_run <= ready_run - 1;
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_tready <= 1'b1;
               ready_run  <= $urandom_range(20, 80);
            end
            3: begin
               rsp_tready <= 1'b0;
               ready_run  <= $urandom_range(1, 10);
            end
            default: begin
               rsp_tready <= 1'($urandom_range(0, 1));
               ready_run  <= $urandom_range(0, 3);
            end
         endcase
      end
   end

   // result checker: each accepted word against the oldest expectation
   always @(posedge clock) begin
      lsef_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (line_results.size() == 0) begin
            flag_mismatch("unexpected result word", 32'(rsp_tdata), 32'(0));
         end else begin
            want = line_results.pop_front();
            if (rsp_tdata[6:0] !== want.left_edge)
               flag_mismatch("left_edge", 32'(rsp_tdata[6:0]), 32'(want.left_edge));
            if (rsp_tdata[13:7] !== want.right_edge)
               flag_mismatch("right_edge", 32'(rsp_tdata[13:7]), 32'(want.right_edge));
            if (rsp_tdata[20:14] !== want.centre)
               flag_mismatch("centre", 32'(rsp_tdata[20:14]), 32'(want.centre));
            if (rsp_tuser[0] !== want.fell_back)
               flag_mismatch("fell_back", 32'(rsp_tuser[0]), 32'(want.fell_back));
         end
      end
   end

   // stimulus and end of run
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (drill_rows[n]) begin
         for (int k = 0; k < drill_rows[n].count; k++)
            push_pixel(drill_rows[n].pixel,
                       drill_rows[n].last && (k == drill_rows[n].count - 1));
         if (drill_rows[n].typed)
            line_results[line_results.size() - 1] = drill_rows[n].want;
      end
      drain_results();

      // window end, one past it, a full line and an overlong one
      send_line(WIN_END);
      send_line(WIN_END + 1);
      send_line(LINE_LEN);
      send_line(LINE_LEN + 32);

      // random lines
      while (words_sent < RANDOM_WORDS || lines_sent < RANDOM_LINES) begin
         if (lines_sent == 4) begin
            // receiver holds off while short lines keep coming: block fills up
            choke_asks <= choke_asks + 1;
            repeat (40) send_line($urandom_range(1, 3));
         end
         if (lines_sent == 60)
            drain_results();
         send_line(pick_length());
      end

      drain_results();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // run limit
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
